// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared property wrappers for the task queue checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SPTQ_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SPTQ_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sptq_pkg.sv =====
// ----------------------------------------------------------------------------
// sptq_pkg
// Types and constants shared by the stable priority task queue.
// ----------------------------------------------------------------------------
package sptq_pkg;

  localparam int CAPACITY_DEF     = 16;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam int PRIO_W    = 15;
  localparam int IN_PAY_W  = 32;
  localparam int OUT_PAY_W = 32;
  localparam int OCC_W     = 5;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 56;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_EMPTY    = 2'd1,
    STS_FULL     = 2'd2,
    STS_NEGATIVE = 2'd3
  } status_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

endpackage

// ===== rtl/sptq_ctrl.sv =====
// ----------------------------------------------------------------------------
// sptq_ctrl
// Handshake controller: accepts a request, issues it to the datapath and
// tracks the held result.
// ----------------------------------------------------------------------------
module sptq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_op,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output sptq_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_HOLD = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   accept;

  assign in_ready  = (state == ST_IDLE) || out_ready;
  assign out_valid = (state == ST_HOLD);
  assign accept    = in_valid && in_ready;

  assign cmd.load = accept;
  assign cmd.op   = sptq_pkg::op_t'(in_op);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_ready && !accept) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/sptq_dpath.sv =====
// ----------------------------------------------------------------------------
// sptq_dpath
// Sorted shift-register store with parallel compare, entry count and
// registered result.
// ----------------------------------------------------------------------------
module sptq_dpath #(
  parameter int CAPACITY     = sptq_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = sptq_pkg::PAYLOAD_BITS_DEF,
  localparam int CW          = $clog2(CAPACITY + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  input  sptq_pkg::cmd_t                   cmd,
  input  logic [15:0]                      priority_req,
  input  logic [sptq_pkg::IN_PAY_W-1:0]    payload,
  output sptq_pkg::status_t                status,
  output logic [sptq_pkg::PRIO_W-1:0]      out_priority,
  output logic [sptq_pkg::OUT_PAY_W-1:0]   out_payload,
  output logic [sptq_pkg::OCC_W-1:0]       occupancy,
  output logic [CW-1:0]                    count
);

  logic [sptq_pkg::PRIO_W-1:0] prio [CAPACITY];
  logic [PAYLOAD_BITS-1:0]     pay  [CAPACITY];
  logic [CAPACITY-1:0]         le;

  logic [sptq_pkg::PRIO_W-1:0]  new_prio;
  logic [PAYLOAD_BITS-1:0]      new_pay;
  logic [63:0]                  in_pay_ext;
  logic [63:0]                  head_pay_ext;
  logic [8:0]                   cnt_ext;
  logic                         neg;
  logic                         full;
  logic                         ins_ok;
  logic                         pop_ok;
  logic [CW-1:0]                count_next;
  sptq_pkg::status_t            st_c;
  logic [sptq_pkg::PRIO_W-1:0]  rprio_c;
  logic [sptq_pkg::OUT_PAY_W-1:0] rpay_c;

  assign new_prio     = priority_req[sptq_pkg::PRIO_W-1:0];
  assign in_pay_ext   = 64'(payload);
  assign new_pay      = in_pay_ext[PAYLOAD_BITS-1:0];
  assign head_pay_ext = 64'(pay[0]);
  assign neg          = priority_req[15];
  assign full         = (count == CW'(CAPACITY));

  // entries at or below the new priority stay in place
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cmp
    assign le[i] = (CW'(i) < count) && (prio[i] <= new_prio);
  end

  always_comb begin
    st_c       = sptq_pkg::STS_OK;
    count_next = count;
    rprio_c    = '0;
    rpay_c     = '0;
    ins_ok     = 1'b0;
    pop_ok     = 1'b0;
    if (cmd.load) begin
      unique case (cmd.op)
        sptq_pkg::OP_INSERT: begin
          if (neg) begin
            st_c = sptq_pkg::STS_NEGATIVE;
          end else if (full) begin
            st_c = sptq_pkg::STS_FULL;
          end else begin
            ins_ok     = 1'b1;
            count_next = count + CW'(1);
          end
        end
        sptq_pkg::OP_POP: begin
          if (count == '0) begin
            st_c = sptq_pkg::STS_EMPTY;
          end else begin
            pop_ok     = 1'b1;
            rprio_c    = prio[0];
            rpay_c     = head_pay_ext[sptq_pkg::OUT_PAY_W-1:0];
            count_next = count - CW'(1);
          end
        end
        sptq_pkg::OP_CLEAR: begin
          count_next = '0;
        end
        sptq_pkg::OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_slot
    always_ff @(posedge clk) begin
      if (ins_ok && !le[i]) begin
        if (i == 0) begin
          prio[i] <= new_prio;
          pay[i]  <= new_pay;
        end else if (le[(i == 0) ? 0 : i - 1]) begin
          prio[i] <= new_prio;
          pay[i]  <= new_pay;
        end else begin
          prio[i] <= prio[(i == 0) ? 0 : i - 1];
          pay[i]  <= pay[(i == 0) ? 0 : i - 1];
        end
      end else if (pop_ok && (i < CAPACITY - 1)) begin
        prio[i] <= prio[(i < CAPACITY - 1) ? i + 1 : i];
        pay[i]  <= pay[(i < CAPACITY - 1) ? i + 1 : i];
      end
    end
  end

  assign cnt_ext = 9'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      status       <= st_c;
      out_priority <= rprio_c;
      out_payload  <= rpay_c;
      occupancy    <= cnt_ext[sptq_pkg::OCC_W-1:0];
    end
  end

endmodule

// ===== rtl/stable_priority_task_queue.sv =====
// ----------------------------------------------------------------------------
// stable_priority_task_queue
// Bounded task queue sorted by ascending priority, stable for equal
// priorities, with insert, pop-front and clear requests.
// ----------------------------------------------------------------------------
//  channel   | dir | tuser          | tdata (low bit up)
//  s_axis    | in  | opcode[1:0]    | priority_req[15:0], payload[31:0]
//  m_axis    | out | status[1:0]    | out_priority[14:0], out_payload[31:0],
//            |     |                | occupancy[4:0], zero pad[3:0]
//
//  Each request is served by the sorted shift-register store, which
//  compares all entries in parallel; the result is registered.
//  A new request is taken whenever no result is held or the held one is
//  taken in the same cycle, so one request per cycle when m_tready is high.
//  Synchronous reset empties the queue and drops any held result.
//  A stall on m_tready holds the result and stalls s_tready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stable_priority_task_queue #(
  parameter int CAPACITY     = sptq_pkg::CAPACITY_DEF,
  parameter int PAYLOAD_BITS = sptq_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // priority_req[15:0], payload[47:16]
  input  logic [sptq_pkg::IN_DATA_W-1:0]    s_tdata,
  // opcode[1:0]
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // out_priority[14:0], out_payload[46:15], occupancy[51:47], zeros[55:52]
  output logic [sptq_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status[1:0]
  output logic [1:0]                        m_tuser
);

  localparam int CW = $clog2(CAPACITY + 1);

  sptq_pkg::cmd_t                  cmd;
  sptq_pkg::status_t               status;
  logic [sptq_pkg::PRIO_W-1:0]     out_priority;
  logic [sptq_pkg::OUT_PAY_W-1:0]  out_payload;
  logic [sptq_pkg::OCC_W-1:0]      occupancy;
  logic [CW-1:0]                   count;

  sptq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_op     (s_tuser),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd)
  );

  sptq_dpath #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .priority_req (s_tdata[15:0]),
    .payload      (s_tdata[47:16]),
    .status       (status),
    .out_priority (out_priority),
    .out_payload  (out_payload),
    .occupancy    (occupancy),
    .count        (count)
  );

  assign m_tuser = status;
  assign m_tdata = {4'b0, occupancy, out_payload, out_priority};

  `SPTQ_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CW'(CAPACITY), "count over capacity")
  `SPTQ_ASSERT_IMP(a_no_overwrite, clk, rst, s_tvalid && s_tready, !m_tvalid || m_tready, "held result overwritten")
  `SPTQ_ASSERT_NXT(a_pop_dec, clk, rst, cmd.load && cmd.op == sptq_pkg::OP_POP && count != '0, count == $past(count) - CW'(1), "pop did not shrink queue")
  `SPTQ_ASSERT_IMP(a_full_flag, clk, rst, m_tvalid && status == sptq_pkg::STS_FULL, count == CW'(CAPACITY), "full status below capacity")

endmodule
